[src/sha256_hash_engine_macros.svh]
// Assertion macros shared by the SHA-256 engine RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef SHA256_HASH_ENGINE_MACROS_SVH
`define SHA256_HASH_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define SHA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sha256 engine check failed");
// Next-cycle implication, disabled during reset
`define SHA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sha256 engine check failed");
`else
`define SHA_ASSERT_NOW(label, ante, cons)
`define SHA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[src/sha256_pkg.sv]
// Shared types, constants and functions of the SHA-256 engine.
// No dependencies; imported by the message buffer, the round unit and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sha256_pkg;

    localparam int LEN_W   = 61;
    localparam int LANES   = 64;

    // Controls for the message buffer / schedule
    typedef struct packed {
        logic        shift;      // advance schedule by one word
        logic        wr_en;      // merge message bytes at wr_base
        logic [5:0]  wr_base;
        logic [2:0]  wr_count;
        logic [31:0] wr_data;    // first byte in bits 31..24
        logic        mark_en;    // 0x80 at wr_base, zeros above it
        logic        len_en;     // length into bytes 56..63
        logic        clear_en;   // zeros into bytes 0..55
        logic [63:0] len_bits;
    } msg_ctrl_t;

    // Controls for the round unit
    typedef struct packed {
        logic       hash_init;   // back to the initial hash value
        logic       var_load;    // a..h <= hash
        logic       round_en;    // one compression round
        logic       fold;        // hash += a..h
        logic [5:0] round;
    } core_ctrl_t;

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    // Initial hash value
    function automatic logic [31:0] iv_word(input logic [2:0] i);
        logic [31:0] v;
        case (i)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    // Round constants
    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

[src/sha256_hash_engine.sv]
// SHA-256 engine top level: request sequencer, byte packing, length count and
// digest output; instantiates sha256_msg_sched and sha256_core, uses sha256_pkg.
// Each request carries one big-endian word with 0 to 4 valid bytes (count in
// tdata, values above 4 count as 4); tlast ends the message and the eight
// digest words follow h0 first, tlast on the eighth. One request is handled at
// a time: each word is accepted, then its bytes are merged, and each full
// 64-byte block adds 64 rounds on the single round unit, a fold and a resume
// (the load shares the merge cycle). The last word adds padding with the load,
// 64 rounds and a fold, and a second such pass when the length needs an extra
// block, then the digest words, one per accepted word.
`timescale 1ns / 1ps
`default_nettype none

module sha256_hash_engine (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // [31:0] data_word, [34:32] byte_count, [39:35] zero
    input  wire         s_tlast,   // last_item
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
    output logic        m_tlast    // digest_last
);
    import sha256_pkg::*;
    `include "sha256_hash_engine_macros.svh"

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ABSORB = 3'd1;
    localparam logic [2:0] ST_PAD    = 3'd2;
    localparam logic [2:0] ST_LEN    = 3'd3;
    localparam logic [2:0] ST_ROUND  = 3'd4;
    localparam logic [2:0] ST_FOLD   = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    // Where to go after a block is folded in
    localparam logic [1:0] RET_ABSORB = 2'd0;
    localparam logic [1:0] RET_LEN    = 2'd1;
    localparam logic [1:0] RET_OUT    = 2'd2;

    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [5:0] LEN_START  = 6'd55;   // last marker slot with room for length
    localparam logic [2:0] MAX_BYTES  = 3'd4;
    localparam logic [2:0] IDX_LAST   = 3'd7;
    localparam logic [6:0] BLOCK_SZ   = 7'd64;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        ret_reg, ret_next;
    logic [5:0]        round_reg, round_next;
    logic [5:0]        fill_reg, fill_next;
    logic [LEN_W-1:0]  total_reg, total_next;
    logic [31:0]       pend_reg, pend_next;
    logic [2:0]        rem_reg, rem_next;
    logic              last_reg, last_next;
    logic [2:0]        idx_reg, idx_next;

    logic [6:0]        space;
    logic [2:0]        n_bytes;
    logic [6:0]        fill_sum;
    logic [2:0]        cnt_sat;
    logic              go_round;
    logic              hash_init;
    logic [31:0]       sched_w;
    logic [31:0]       digest;
    msg_ctrl_t         msg_ctrl;
    core_ctrl_t        core_ctrl;

    // Bytes that fit into the current block
    assign space    = BLOCK_SZ - {1'b0, fill_reg};
    assign n_bytes  = ({4'b0, rem_reg} < space) ? rem_reg : space[2:0];
    assign fill_sum = {1'b0, fill_reg} + {4'b0, n_bytes};
    assign cnt_sat  = (s_tdata[34:32] > MAX_BYTES) ? MAX_BYTES : s_tdata[34:32];

    // Sequencer
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        round_next = round_reg;
        fill_next  = fill_reg;
        total_next = total_reg;
        pend_next  = pend_reg;
        rem_next   = rem_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        go_round   = 1'b0;
        hash_init  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    pend_next  = s_tdata[31:0];
                    rem_next   = cnt_sat;
                    last_next  = s_tlast;
                    state_next = ST_ABSORB;
                end
            end
            ST_ABSORB: begin
                total_next = total_reg + LEN_W'(n_bytes);
                rem_next   = rem_reg - n_bytes;
                pend_next  = pend_reg << {n_bytes, 3'b000};
                if (fill_sum == BLOCK_SZ) begin
                    fill_next = '0;
                    ret_next  = RET_ABSORB;
                    go_round  = 1'b1;
                end else begin
                    fill_next = fill_sum[5:0];
                    if (rem_reg == n_bytes) begin
                        state_next = last_reg ? ST_PAD : ST_IDLE;
                    end
                end
            end
            ST_PAD: begin
                fill_next = '0;
                ret_next  = (fill_reg <= LEN_START) ? RET_OUT : RET_LEN;
                go_round  = 1'b1;
            end
            ST_LEN: begin
                ret_next = RET_OUT;
                go_round = 1'b1;
            end
            ST_ROUND: begin
                round_next = round_reg + 6'd1;
                if (round_reg == LAST_ROUND) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                case (ret_reg)
                    RET_ABSORB: state_next = ST_ABSORB;
                    RET_LEN:    state_next = ST_LEN;
                    RET_OUT:    state_next = ST_OUT;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_OUT: begin
                if (m_tready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == IDX_LAST) begin
                        hash_init  = 1'b1;
                        total_next = '0;
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (go_round) begin
            state_next = ST_ROUND;
            round_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= RET_ABSORB;
            round_reg <= '0;
            fill_reg  <= '0;
            total_reg <= '0;
            rem_reg   <= '0;
            last_reg  <= 1'b0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            round_reg <= round_next;
            fill_reg  <= fill_next;
            total_reg <= total_next;
            rem_reg   <= rem_next;
            last_reg  <= last_next;
            idx_reg   <= idx_next;
        end
    end

    // Payload holding register
    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
    end

    // Buffer and round unit controls
    always_comb begin
        msg_ctrl.shift    = (state_reg == ST_ROUND);
        msg_ctrl.wr_en    = (state_reg == ST_ABSORB);
        msg_ctrl.wr_base  = fill_reg;
        msg_ctrl.wr_count = n_bytes;
        msg_ctrl.wr_data  = pend_reg;
        msg_ctrl.mark_en  = (state_reg == ST_PAD);
        msg_ctrl.len_en   = ((state_reg == ST_PAD) && (fill_reg <= LEN_START))
                          || (state_reg == ST_LEN);
        msg_ctrl.clear_en = (state_reg == ST_LEN);
        msg_ctrl.len_bits = {total_reg, 3'b000};

        core_ctrl.hash_init = hash_init;
        core_ctrl.var_load  = go_round;
        core_ctrl.round_en  = (state_reg == ST_ROUND);
        core_ctrl.fold      = (state_reg == ST_FOLD);
        core_ctrl.round     = round_reg;
    end

    sha256_msg_sched u_msg (
        .aclk (aclk),
        .ctrl (msg_ctrl),
        .w_o  (sched_w)
    );

    sha256_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (core_ctrl),
        .w_i      (sched_w),
        .rd_idx   (idx_reg),
        .digest_o (digest)
    );

    // Ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {5'b00000, idx_reg, digest};
    assign m_tlast  = (idx_reg == IDX_LAST);

    `SHA_ASSERT_NOW(a_no_overlap, s_tready, !m_tvalid)
    `SHA_ASSERT_NEXT(a_accept_absorb, s_tvalid && s_tready, state_reg == ST_ABSORB)
    `SHA_ASSERT_NOW(a_fill_bound, state_reg == ST_ABSORB, fill_sum <= BLOCK_SZ)
    `SHA_ASSERT_NEXT(a_round_end, (state_reg == ST_ROUND) && (round_reg == LAST_ROUND), state_reg == ST_FOLD)
    `SHA_ASSERT_NEXT(a_digest_done, m_tvalid && m_tready && m_tlast, s_tready && (fill_reg == 6'd0) && (total_reg == '0))

endmodule

`default_nettype wire

[src/sha256_msg_sched.sv]
// Message block buffer (64 byte lanes) with byte merge, padding and the
// rolling 16-word message schedule. Depends on sha256_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sha256_msg_sched (
    input  wire                    aclk,
    input  sha256_pkg::msg_ctrl_t  ctrl,
    output logic [31:0]            w_o
);
    import sha256_pkg::*;

    logic [7:0]  buf_reg  [LANES];
    logic [7:0]  buf_next [LANES];
    logic [31:0] word     [16];
    logic [31:0] new_word;

    // Word view of the byte lanes, big-endian
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            word[i] = {buf_reg[4*i], buf_reg[4*i+1], buf_reg[4*i+2], buf_reg[4*i+3]};
        end
    end

    // Schedule expansion: W[t+16] from W[t], W[t+1], W[t+9], W[t+14]
    assign new_word = small_sigma1(word[14]) + word[9] + small_sigma0(word[1]) + word[0];
    assign w_o      = word[0];

    // Per-lane next value
    always_comb begin
        logic [5:0] off;
        off = '0;
        for (int j = 0; j < LANES; j++) begin
            buf_next[j] = buf_reg[j];
            off = 6'(j) - ctrl.wr_base;
            if (ctrl.shift) begin
                if (j < LANES - 4) begin
                    buf_next[j] = buf_reg[6'(j + 4)];
                end else begin
                    buf_next[j] = new_word[8*(LANES-1-j) +: 8];
                end
            end else begin
                // message bytes
                if (ctrl.wr_en && (6'(j) >= ctrl.wr_base) && (off < {3'b000, ctrl.wr_count})) begin
                    buf_next[j] = ctrl.wr_data[8*(3-off[1:0]) +: 8];
                end
                // end marker and zero fill after it
                if (ctrl.mark_en && (6'(j) == ctrl.wr_base)) begin
                    buf_next[j] = 8'h80;
                end else if (ctrl.mark_en && (6'(j) > ctrl.wr_base)) begin
                    buf_next[j] = 8'h00;
                end
                // extra padding block
                if (ctrl.clear_en && (j < LANES - 8)) begin
                    buf_next[j] = 8'h00;
                end
                // bit length, big-endian in the last eight bytes
                if (ctrl.len_en && (j >= LANES - 8)) begin
                    buf_next[j] = ctrl.len_bits[8*(LANES-1-j) +: 8];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < LANES; j++) begin
            buf_reg[j] <= buf_next[j];
        end
    end

endmodule

`default_nettype wire

[src/sha256_core.sv]
// Compression round unit: hash state, a..h working registers and the one
// shared round datapath. Depends on sha256_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sha256_core (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  sha256_pkg::core_ctrl_t ctrl,
    input  wire  [31:0]            w_i,
    input  wire  [2:0]             rd_idx,
    output logic [31:0]            digest_o
);
    import sha256_pkg::*;

    logic [31:0] hash_reg [8];
    logic [31:0] var_reg  [8];
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    // Round function
    assign ch  = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
    assign maj = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
               ^ (var_reg[1] & var_reg[2]);
    assign t1  = var_reg[7] + big_sigma1(var_reg[4]) + ch + round_k(ctrl.round) + w_i;
    assign t2  = big_sigma0(var_reg[0]) + maj;

    assign digest_o = hash_reg[rd_idx];

    // Hash state: initial value on reset and after each digest
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.hash_init) begin
            for (int i = 0; i < 8; i++) begin
                hash_reg[i] <= iv_word(3'(i));
            end
        end else if (ctrl.fold) begin
            for (int i = 0; i < 8; i++) begin
                hash_reg[i] <= hash_reg[i] + var_reg[i];
            end
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (ctrl.var_load) begin
            for (int i = 0; i < 8; i++) begin
                var_reg[i] <= hash_reg[i];
            end
        end else if (ctrl.round_en) begin
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
        end
    end

endmodule

`default_nettype wire

[tb/sv/sha256_digest_checker.sv]
// Digest checker for the SHA-256 engine: watches both stream channels, predicts each digest.
// Stand-alone; instantiated by tb_sha256_hash_engine beside the engine under test.
`timescale 1ns / 1ps

module sha256_digest_checker (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    input  wire        s_tready,
    input  wire [39:0] s_tdata,   // [31:0] data_word, [34:32] byte_count, [39:35] zero
    input  wire        s_tlast,   // last_item
    input  wire        m_tvalid,
    input  wire        m_tready,
    input  wire [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
    input  wire        m_tlast,   // digest_last
    output int         fail_count,
    output int         pending
);

    localparam logic [0:63][31:0] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [0:7][31:0] HASH_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam int MAX_BYTES = 4;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  pos;
        logic        tail;
    } digest_rec_t;

    // predicted engine state
    logic [31:0]  hash_acc [8];
    logic [7:0]   block_bytes [64];
    int unsigned  block_fill;
    logic [60:0]  msg_bytes;      // wraps at 2^61 like the length counter

    digest_rec_t  digest_q [$];
    digest_rec_t  want;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic restart_message();
        for (int i = 0; i < 8; i++) hash_acc[i] = HASH_IV[i];
        for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
        block_fill = 0;
        msg_bytes  = '0;
    endtask

    // 64-round compression of the current block into hash_acc
    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        for (int i = 0; i < 8; i++) v[i] = hash_acc[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_acc[i] = hash_acc[i] + v[i];
    endtask

    task automatic push_byte(input logic [7:0] b);
        block_bytes[block_fill] = b;
        block_fill++;
        if (block_fill == 64) begin
            compress_block();
            block_fill = 0;
        end
    endtask

    // one accepted request: append its bytes, pad and queue the digest on last
    task automatic absorb_request(input logic [31:0] data, input logic [2:0] cnt,
                                  input logic fin);
        int unsigned n;
        logic [63:0] bit_len;
        n = (cnt > MAX_BYTES) ? MAX_BYTES : cnt;
        for (int i = 0; i < n; i++) begin
            push_byte(data[31-8*i -: 8]);
            msg_bytes = msg_bytes + 61'd1;
        end
        if (fin) begin
            push_byte(8'h80);
            while (block_fill != 56) push_byte(8'h00);
            bit_len = {msg_bytes, 3'b000};
            for (int i = 0; i < 8; i++) push_byte(bit_len[63-8*i -: 8]);
            for (int i = 0; i < 8; i++)
                digest_q.push_back('{value: hash_acc[i], pos: i[2:0], tail: (i == 7)});
            restart_message();
        end
    endtask

    // monitor both channels
    always @(posedge aclk) begin
        if (!aresetn) begin
            restart_message();
        end else begin
            if (s_tvalid && s_tready)
                absorb_request(s_tdata[31:0], s_tdata[34:32], s_tlast);
            if (m_tvalid && m_tready) begin
                if (digest_q.size() == 0) begin
                    $display("%0t: unexpected digest word: expected none, got %h",
                             $time, m_tdata[31:0]);
                    fail_count++;
                end else begin
                    want = digest_q.pop_front();
                    if (m_tdata[31:0] !== want.value) begin
                        $display("%0t: digest_word expected %h got %h",
                                 $time, want.value, m_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_tdata[34:32] !== want.pos) begin
                        $display("%0t: word_index expected %0d got %0d",
                                 $time, want.pos, m_tdata[34:32]);
                        fail_count++;
                    end
                    if (m_tlast !== want.tail) begin
                        $display("%0t: digest_last expected %b got %b",
                                 $time, want.tail, m_tlast);
                        fail_count++;
                    end
                end
            end
            pending <= digest_q.size();
        end
    end

endmodule

[tb/sv/tb_sha256_hash_engine.sv]
// Top of the SHA-256 engine testbench: clock, reset, message stimulus and verdict.
// Depends on sha256_hash_engine and sha256_digest_checker.
`timescale 1ns / 1ps

module tb_sha256_hash_engine;

    localparam int RAND_ITEMS   = 450;
    localparam int IDLE_LIMIT   = 4000;   // cycles with no request on either side
    localparam int LONG_HOLD    = 700;
    localparam int DRAIN_CYCLES = 20;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // [31:0] data_word, [34:32] byte_count, [39:35] zero
    logic        s_tlast  = 1'b0; // last_item
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // [31:0] digest_word, [34:32] word_index, [39:35] zero
    logic        m_tlast;         // digest_last

    int          fail_count;
    int          pending;
    int          items_sent = 0;
    bit          s_calm = 1'b0;

    sha256_hash_engine uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    sha256_digest_checker digest_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // one input request, preceded by a random gap unless in a calm stretch
    task automatic send_word(input logic [31:0] data, input logic [2:0] cnt, input logic fin);
        int gap;
        gap = s_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {5'b0, cnt, data};
        s_tlast  <= fin;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // well-formed message: mostly full words, random byte count on the last one
    task automatic send_random_message();
        int nwords;
        int pick;
        logic [2:0] cnt;
        pick = $urandom_range(0, 99);
        if (pick < 70)      nwords = $urandom_range(1, 20);
        else if (pick < 95) nwords = $urandom_range(21, 40);
        else                nwords = $urandom_range(41, 70);
        s_calm = ($urandom_range(0, 4) == 0);
        for (int k = 0; k < nwords; k++) begin
            if (k == nwords - 1 || $urandom_range(0, 9) >= 8) cnt = $urandom_range(0, 7);
            else cnt = 3'd4;
            send_word($urandom, cnt, k == nwords - 1);
        end
    endtask

    // stimulus and verdict
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty message: padding only
        send_word(32'h0000_0000, 3'd0, 1'b1);
        // three-byte message, low byte ignored
        send_word(32'h6162_63ff, 3'd3, 1'b1);
        // 56 bytes: length spills into an extra block
        for (int k = 0; k < 14; k++)
            send_word(32'ha5c3_0000 | k, 3'd4, k == 13);
        // zero count mid-message, partial words, saturating counts
        send_word(32'h0000_0000, 3'd0, 1'b0);
        send_word(32'hdead_beef, 3'd2, 1'b0);
        send_word(32'hffff_ffff, 3'd7, 1'b0);
        send_word(32'h1234_5678, 3'd1, 1'b0);
        send_word(32'hffff_ffff, 3'd5, 1'b1);
        // single zero word
        send_word(32'h0000_0000, 3'd4, 1'b1);

        items_sent = 0;
        while (items_sent < RAND_ITEMS) send_random_message();
        s_tvalid <= 1'b0;

        // let the checker count the digest of the final request
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // result sink: random stalls, calm stretches and a couple of long hold-offs
    initial begin : result_sink
        int got;
        int hold;
        bit calm;
        got  = 0;
        calm = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (got % 8 == 0) calm = ($urandom_range(0, 4) == 0);
            hold = calm ? 0 : $urandom_range(0, 11);
            if (got == 16 || got == 160) hold = LONG_HOLD;
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            got++;
        end
    end

    // watchdog on cycles without any request
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
            else idle++;
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule
